// File: design/sis_pkg.sv
package sis_pkg;

    localparam int SIS_DEPTH = 32;
    localparam int KEY_W     = 32;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DRAIN  = 1'b1;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_DROPPED = 2'd1,
        ST_ELEMENT = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_DRAIN
    } fsm_state_t;

    typedef struct packed {
        logic                     req_type;
        logic signed [KEY_W-1:0]  key_value;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [KEY_W-1:0]  out_value;
        logic                     last_flag;
    } rsp_t;

    typedef struct packed {
        logic ins;
        logic shift;
    } cell_ctl_t;

endpackage

// File: design/sorted_insertion_store_core.sv
// Channel   Handshake             Payload                       Direction
// request   start & !busy         req_type, key_value           in
// result    strobe (one cycle)    status, out_value, last_flag  out
//
// An insert enters the cell row unless it is full; its result shows in the cycle after the request.
// A drain of N keys streams N results on consecutive cycles, one cell shift
// each; busy stays high while the remaining keys shift out. An empty drain gives one result.
// Reset empties the row by clearing every cell's valid bit at once.
// The receiver cannot stall; every strobe marks exactly one result.
module sorted_insertion_store_core #(
    parameter int DEPTH = sis_pkg::SIS_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sis_pkg::req_t request,
    output logic          strobe,
    output sis_pkg::rsp_t result
);
    import sis_pkg::*;

    cell_ctl_t               ctl;
    logic signed [KEY_W-1:0] cell_value [DEPTH];
    logic                    cell_valid [DEPTH];
    logic                    cell_after [DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [KEY_W-1:0] lv;
            logic                    lval;
            logic                    laft;
            logic signed [KEY_W-1:0] rv;
            logic                    rval;

            if (gi == 0)
            begin : g_first
                assign lv   = '0;
                assign lval = 1'b0;
                assign laft = 1'b1;
            end
            else
            begin : g_mid
                assign lv   = cell_value[gi-1];
                assign lval = cell_valid[gi-1];
                assign laft = cell_after[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign rv   = '0;
                assign rval = 1'b0;
            end
            else
            begin : g_inner
                assign rv   = cell_value[gi+1];
                assign rval = cell_valid[gi+1];
            end

            sis_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .key         (request.key_value),
                .left_value  (lv),
                .left_valid  (lval),
                .left_after  (laft),
                .right_value (rv),
                .right_valid (rval),
                .value       (cell_value[gi]),
                .valid       (cell_valid[gi]),
                .after       (cell_after[gi])
            );
        end
    endgenerate

    sis_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .head_value   (cell_value[0]),
        .head_valid   (cell_valid[0]),
        .second_valid (cell_valid[1]),
        .full         (cell_valid[DEPTH-1]),
        .ctl          (ctl),
        .busy         (busy),
        .strobe       (strobe),
        .result       (result)
    );

endmodule

// File: design/sis_cell.sv
module sis_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sis_pkg::cell_ctl_t               ctl,
    input  logic signed [sis_pkg::KEY_W-1:0] key,
    input  logic signed [sis_pkg::KEY_W-1:0] left_value,
    input  logic                             left_valid,
    input  logic                             left_after,
    input  logic signed [sis_pkg::KEY_W-1:0] right_value,
    input  logic                             right_valid,
    output logic signed [sis_pkg::KEY_W-1:0] value,
    output logic                             valid,
    output logic                             after
);
    import sis_pkg::*;

    logic signed [KEY_W-1:0] value_reg;
    logic signed [KEY_W-1:0] value_next;
    logic                    valid_reg;
    logic                    valid_next;

    assign after = valid_reg && (value_reg <= key);
    assign value = value_reg;
    assign valid = valid_reg;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.shift)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctl.ins && !after)
        begin
            if (left_after)
            begin
                value_next = key;
                valid_next = 1'b1;
            end
            else
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: design/sis_ctrl.sv
module sis_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  sis_pkg::req_t                    request,
    input  logic signed [sis_pkg::KEY_W-1:0] head_value,
    input  logic                             head_valid,
    input  logic                             second_valid,
    input  logic                             full,
    output sis_pkg::cell_ctl_t               ctl,
    output logic                             busy,
    output logic                             strobe,
    output sis_pkg::rsp_t                    result
);
    import sis_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;
    rsp_t       rsp_reg;
    rsp_t       rsp_next;
    logic       strobe_reg;
    logic       strobe_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (start && request.req_type == REQ_DRAIN && head_valid && second_valid)
                begin
                    state_next = FSM_DRAIN;
                end
            end
            FSM_DRAIN:
            begin
                if (!second_valid)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl         = '0;
        busy        = 1'b0;
        strobe_next = 1'b0;
        rsp_next    = rsp_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    strobe_next = 1'b1;
                    if (request.req_type == REQ_INSERT)
                    begin
                        ctl.ins            = !full;
                        rsp_next.status    = full ? ST_DROPPED : ST_STORED;
                        rsp_next.out_value = request.key_value;
                        rsp_next.last_flag = 1'b1;
                    end
                    else if (!head_valid)
                    begin
                        rsp_next.status    = ST_EMPTY;
                        rsp_next.out_value = '0;
                        rsp_next.last_flag = 1'b1;
                    end
                    else
                    begin
                        ctl.shift          = 1'b1;
                        rsp_next.status    = ST_ELEMENT;
                        rsp_next.out_value = head_value;
                        rsp_next.last_flag = !second_valid;
                    end
                end
            end
            FSM_DRAIN:
            begin
                busy               = 1'b1;
                ctl.shift          = 1'b1;
                strobe_next        = 1'b1;
                rsp_next.status    = ST_ELEMENT;
                rsp_next.out_value = head_value;
                rsp_next.last_flag = !second_valid;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FSM_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign strobe = strobe_reg;
    assign result = rsp_reg;

endmodule

// File: design/sis_checker.sv
module sis_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input sis_pkg::req_t request,
    input logic          strobe,
    input sis_pkg::rsp_t result
);
    import sis_pkg::*;

    a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.req_type == REQ_INSERT |=>
            strobe && result.last_flag &&
            (result.status == ST_STORED || result.status == ST_DROPPED))
        else $error("insert request without single stored/dropped result");

    a_drain_streams: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> strobe && result.status == ST_ELEMENT)
        else $error("drain gap in element stream");

    a_element_follows: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status == ST_ELEMENT && !result.last_flag |=>
            strobe && result.status == ST_ELEMENT)
        else $error("element stream ended without last flag");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status == ST_EMPTY |-> result.last_flag && result.out_value == '0)
        else $error("empty result malformed");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && result.last_flag)
        else $error("drain ended without final element");

endmodule

bind sorted_insertion_store_core sis_checker u_sis_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
);
